### rtl/bdhd_pkg.sv
// Package for the button debounce / hold detector.
// Holds the status encoding, register indexes, field widths and the config bundle.
// No dependencies.
package bdhd_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned MsW     = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW  = 40;  // pin_level + now_ms, padded to bytes
  localparam int unsigned OutDataW = 8;   // button_status, padded to a byte

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INVERT   = 2'd2;

  localparam logic [MsW-1:0] DebounceRst = 16'd50;
  localparam logic [MsW-1:0] HoldRst     = 16'd0;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PRESSED = 2'd1,
    ST_CHANGE  = 2'd2,
    ST_HELD    = 2'd3
  } status_e;

  typedef struct packed {
    logic [MsW-1:0] debounce_ms;
    logic [MsW-1:0] hold_ms;
  } cfg_t;

endpackage

### rtl/bdhd_step.sv
// Next-state logic of the debounce / hold detector for one sample.
// Depends on bdhd_pkg.
module bdhd_step (
  input  bdhd_pkg::cfg_t             cfg_i,
  input  bdhd_pkg::status_e          status_i,
  input  logic [bdhd_pkg::TimeW-1:0] stamp_i,
  input  logic                       lvl_i,
  input  logic [bdhd_pkg::TimeW-1:0] now_i,
  output bdhd_pkg::status_e          status_o,
  output logic [bdhd_pkg::TimeW-1:0] stamp_o
);
  import bdhd_pkg::*;

  logic            chg_start;
  logic [TimeW-1:0] age;
  status_e         status_mid;

  always_comb begin
    chg_start  = ((status_i == ST_IDLE) && lvl_i) || ((status_i == ST_PRESSED) && !lvl_i);
    stamp_o    = chg_start ? now_i : stamp_i;
    status_mid = chg_start ? ST_CHANGE : status_i;
    // modulo 2^32 elapsed time
    age        = now_i - stamp_o;
    status_o   = status_mid;
    case (status_mid)
      ST_CHANGE: begin
        if (age > {{(TimeW-MsW){1'b0}}, cfg_i.debounce_ms}) begin
          status_o = lvl_i ? ST_PRESSED : ST_IDLE;
        end
      end
      ST_PRESSED: begin
        if (lvl_i && (age > {{(TimeW-MsW){1'b0}}, cfg_i.hold_ms}) &&
            (cfg_i.hold_ms != '0)) begin
          status_o = ST_HELD;
        end
      end
      ST_HELD: begin
        if (!lvl_i && (age > {{(TimeW-MsW){1'b0}}, cfg_i.hold_ms})) begin
          status_o = ST_IDLE;
        end
      end
      default: begin
        status_o = status_mid;
      end
    endcase
  end

endmodule

### rtl/button_debounce_hold_detector_unit.sv
// Top level of the button debounce / hold detector.
// Depends on bdhd_pkg and bdhd_step.
//
// Usage:
//   Slave stream: one transaction per switch sample. tdata carries pin_level
//   in bit 0 and the free-running millisecond count now_ms in bits 32:1.
//   Master stream: one transaction per sample with the updated button status
//   in tdata bits 1:0 (0 idle, 1 pressed, 2 debouncing, 3 held).
//   Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 debounce_ms, 1 hold_ms, 2 invert_level); index 3 is ignored.
//   Write config only while no sample is in flight.
// Timing:
//   A sample is captured in an input register, then one compare-and-select
//   pass updates the status and change stamp as it loads the result register.
//   Each sample passes the input register and then the result register; throughput
//   is one sample per cycle while the master side does not stall.
// Reset:
//   rst_ni clears both stages, sets status idle, stamp zero, debounce_ms 50,
//   hold_ms 0 and no inversion.
// Stall:
//   When the master side stalls, the result register holds and the input
//   register holds behind it; s_axis_tready drops only once both are full.
module button_debounce_hold_detector_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave stream; tdata: [0] pin_level, [32:1] now_ms, [39:33] zero
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bdhd_pkg::InDataW-1:0]    s_axis_tdata,
  // master stream; tdata: [1:0] button_status, [7:2] zero
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bdhd_pkg::OutDataW-1:0]   m_axis_tdata,
  // config write port
  input  logic                            cfg_we_i,
  input  logic [bdhd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bdhd_pkg::MsW-1:0]        cfg_data_i
);
  import bdhd_pkg::*;

  cfg_t             cfg_q;
  logic             invert_q;

  logic             in_valid_q;
  logic             lvl_q;
  logic [TimeW-1:0] now_q;

  logic             out_valid_q;
  status_e          status_q, status_d;
  logic [TimeW-1:0] stamp_q, stamp_d;

  logic             out_free;
  logic             advance;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= DebounceRst;
      cfg_q.hold_ms     <= HoldRst;
      invert_q          <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE: cfg_q.debounce_ms <= cfg_data_i;
        CFG_HOLD:     cfg_q.hold_ms     <= cfg_data_i;
        CFG_INVERT:   invert_q          <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  // result register is free when empty or being drained this cycle
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // input stage: apply inversion on capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      lvl_q <= s_axis_tdata[0] ^ invert_q;
      now_q <= s_axis_tdata[TimeW:1];
    end
  end

  bdhd_step u_step (
    .cfg_i    (cfg_q),
    .status_i (status_q),
    .stamp_i  (stamp_q),
    .lvl_i    (lvl_q),
    .now_i    (now_q),
    .status_o (status_d),
    .stamp_o  (stamp_d)
  );

  // state and result register: the status register is the result payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= ST_IDLE;
      stamp_q     <= '0;
    end else begin
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        status_q <= status_d;
        stamp_q  <= stamp_d;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-2){1'b0}}, status_q};

`ifndef SYNTHESIS
  // idle never jumps straight to held
  a_no_idle_to_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && status_q == ST_IDLE) |=> status_q != ST_HELD)
    else $error("idle went directly to held");

  // hold disabled keeps pressed out of held
  a_hold_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && status_q == ST_PRESSED && cfg_q.hold_ms == '0) |=> status_q != ST_HELD)
    else $error("held entered with hold disabled");

  // a new stamp always comes with the debouncing status
  a_stamp_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && stamp_d != stamp_q) |=> status_q == ST_CHANGE)
    else $error("stamp moved without starting a debounce");

  // state only moves when a sample is processed
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(status_q) && $stable(stamp_q))
    else $error("state changed without a sample");
`endif

endmodule
